/* rtl/core/messagepack_scalar_encoder_top_defines.svh */
// Assertion macros used by the checker file of the MessagePack encoder
`ifndef MESSAGEPACK_SCALAR_ENCODER_TOP_DEFINES_SVH
`define MESSAGEPACK_SCALAR_ENCODER_TOP_DEFINES_SVH

// same-cycle implication, switched off while dis is high
`define MPSE_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, switched off while dis is high
`define MPSE_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mpse_pkg.sv */
// Package with request codes, tag bytes and queue types of the MessagePack encoder
`timescale 1ns / 1ps

package mpse_pkg;

    typedef enum logic [4:0] {
        REQ_NIL    = 5'd0,
        REQ_TRUE   = 5'd1,
        REQ_FALSE  = 5'd2,
        REQ_ARRAY  = 5'd3,
        REQ_MAP    = 5'd4,
        REQ_UINT   = 5'd5,
        REQ_U8     = 5'd6,
        REQ_U16    = 5'd7,
        REQ_U32    = 5'd8,
        REQ_U64    = 5'd9,
        REQ_SINT   = 5'd10,
        REQ_S8     = 5'd11,
        REQ_S16    = 5'd12,
        REQ_S32    = 5'd13,
        REQ_S64    = 5'd14,
        REQ_F32    = 5'd15,
        REQ_F64    = 5'd16,
        REQ_STR    = 5'd17,
        REQ_RAW    = 5'd18,
        REQ_FIXSTR = 5'd19,
        REQ_STR8   = 5'd20
    } req_type_t;

    localparam logic [7:0] TAG_NIL        = 8'hc0;
    localparam logic [7:0] TAG_BOOL_TRUE  = 8'hc3;
    localparam logic [7:0] TAG_BOOL_FALSE = 8'hc2;
    localparam logic [7:0] TAG_FIXARR     = 8'h90;
    localparam logic [7:0] TAG_MAP_FIX    = 8'h80;
    localparam logic [7:0] TAG_STR_FIX    = 8'ha0;
    localparam logic [7:0] TAG_U8         = 8'hcc;
    localparam logic [7:0] TAG_U16        = 8'hcd;
    localparam logic [7:0] TAG_U32        = 8'hce;
    localparam logic [7:0] TAG_U64        = 8'hcf;
    localparam logic [7:0] TAG_S8         = 8'hd0;
    localparam logic [7:0] TAG_S16        = 8'hd1;
    localparam logic [7:0] TAG_S32        = 8'hd2;
    localparam logic [7:0] TAG_S64        = 8'hd3;
    localparam logic [7:0] TAG_F32        = 8'hca;
    localparam logic [7:0] TAG_F64        = 8'hcb;
    localparam logic [7:0] TAG_STR_8BIT   = 8'hd9;

    localparam logic [15:0] CAPACITY_RESET = 16'd256;

    localparam int MAX_BYTES = 9;
    localparam int LEN_W     = 4;

    typedef struct packed {
        logic [8*MAX_BYTES-1:0] bytes;      // first byte in the top bits
        logic [LEN_W-1:0]       len;        // number of bytes, 1..9
        logic                   byte_valid;
        logic                   success;
    } mpse_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mpse_qstat_t;

endpackage

/* rtl/core/mpse_front.sv */
// Front end: accepts requests, encodes tag and payload, checks room against capacity
`timescale 1ns / 1ps

module mpse_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [4:0]           s_req_type,
    input  logic [63:0]          s_value,
    input  mpse_pkg::mpse_qstat_t qstat,
    output logic                 push,
    output mpse_pkg::mpse_entry_t push_entry
);
    import mpse_pkg::*;

    logic [15:0] capacity_reg, capacity_next;
    logic [15:0] fill_reg, fill_next;

    logic [7:0]  tag;
    logic [3:0]  plen;
    logic        has_elem;
    logic [63:0] payload;
    logic [31:0] w;
    logic [16:0] need;
    logic        room_ok;
    logic        full_ok;

    assign s_ready = !qstat.full;
    assign push    = s_valid && s_ready;
    assign w       = s_value[31:0];

    always_comb begin
        tag      = 8'h00;
        plen     = 4'd0;
        has_elem = 1'b1;
        case (s_req_type)
            REQ_NIL:   tag = TAG_NIL;
            REQ_TRUE:  tag = TAG_BOOL_TRUE;
            REQ_FALSE: tag = TAG_BOOL_FALSE;
            REQ_ARRAY: begin
                has_elem = (s_value[63:4] == '0);
                tag      = TAG_FIXARR | {4'h0, s_value[3:0]};
            end
            REQ_MAP: begin
                has_elem = (s_value[63:4] == '0);
                tag      = TAG_MAP_FIX | {4'h0, s_value[3:0]};
            end
            REQ_UINT, REQ_SINT: begin
                if ((s_req_type == REQ_UINT) || !w[31]) begin
                    if (w[31:7] == '0) begin
                        tag = w[7:0];
                    end else if (w[31:8] == '0) begin
                        tag  = TAG_U8;
                        plen = 4'd1;
                    end else if (w[31:16] == '0) begin
                        tag  = TAG_U16;
                        plen = 4'd2;
                    end else begin
                        tag  = TAG_U32;
                        plen = 4'd4;
                    end
                end else begin
                    if (w[31:5] == '1) begin
                        tag = w[7:0];
                    end else if (w[31:7] == '1) begin
                        tag  = TAG_S8;
                        plen = 4'd1;
                    end else if (w[31:15] == '1) begin
                        tag  = TAG_S16;
                        plen = 4'd2;
                    end else begin
                        tag  = TAG_S32;
                        plen = 4'd4;
                    end
                end
            end
            REQ_U8: begin
                tag  = TAG_U8;
                plen = 4'd1;
            end
            REQ_U16: begin
                tag  = TAG_U16;
                plen = 4'd2;
            end
            REQ_U32: begin
                tag  = TAG_U32;
                plen = 4'd4;
            end
            REQ_U64: begin
                tag  = TAG_U64;
                plen = 4'd8;
            end
            REQ_S8: begin
                tag  = TAG_S8;
                plen = 4'd1;
            end
            REQ_S16: begin
                tag  = TAG_S16;
                plen = 4'd2;
            end
            REQ_S32: begin
                tag  = TAG_S32;
                plen = 4'd4;
            end
            REQ_S64: begin
                tag  = TAG_S64;
                plen = 4'd8;
            end
            REQ_F32: begin
                tag  = TAG_F32;
                plen = 4'd4;
            end
            REQ_F64: begin
                tag  = TAG_F64;
                plen = 4'd8;
            end
            REQ_STR: begin
                if (s_value[63:5] == '0) begin
                    tag = TAG_STR_FIX | {3'b000, s_value[4:0]};
                end else if (s_value[63:8] == '0) begin
                    tag  = TAG_STR_8BIT;
                    plen = 4'd1;
                end else begin
                    has_elem = 1'b0;
                end
            end
            REQ_RAW: tag = s_value[7:0];
            REQ_FIXSTR: begin
                has_elem = (s_value[63:5] == '0);
                tag      = TAG_STR_FIX | {3'b000, s_value[4:0]};
            end
            REQ_STR8: begin
                has_elem = (s_value[63:8] == '0);
                tag      = TAG_STR_8BIT;
                plen     = 4'd1;
            end
            default: has_elem = 1'b0;
        endcase
    end

    // align the payload to the top of the word
    always_comb begin
        case (plen)
            4'd1:    payload = {s_value[7:0], 56'h0};
            4'd2:    payload = {s_value[15:0], 48'h0};
            4'd4:    payload = {s_value[31:0], 32'h0};
            4'd8:    payload = s_value;
            default: payload = 64'h0;
        endcase
    end

    assign need    = {1'b0, fill_reg} + 17'd1 + {13'h0, plen};
    assign room_ok = fill_reg < capacity_reg;
    assign full_ok = need <= {1'b0, capacity_reg};

    always_comb begin
        push_entry.bytes      = '0;
        push_entry.len        = 4'd1;
        push_entry.byte_valid = 1'b0;
        push_entry.success    = 1'b0;
        fill_next             = fill_reg;
        if (has_elem && room_ok) begin
            push_entry.bytes[71:64] = tag;
            push_entry.byte_valid   = 1'b1;
            if (plen == 4'd0) begin
                push_entry.success = 1'b1;
                fill_next          = fill_reg + 16'd1;
            end else if (full_ok) begin
                push_entry.bytes   = {tag, payload};
                push_entry.len     = 4'd1 + plen;
                push_entry.success = 1'b1;
                fill_next          = need[15:0];
            end else begin
                fill_next = fill_reg + 16'd1;
            end
        end
    end

    assign capacity_next = cfg_wr_en ? cfg_wr_data : capacity_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
            fill_reg     <= '0;
        end else begin
            capacity_reg <= capacity_next;
            if (push) begin
                fill_reg <= fill_next;
            end
        end
    end

endmodule

/* rtl/core/mpse_queue.sv */
// Two-entry queue between the front end and the byte sequencer
`timescale 1ns / 1ps

module mpse_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  mpse_pkg::mpse_entry_t push_entry,
    input  logic                  pop,
    output mpse_pkg::mpse_entry_t head,
    output mpse_pkg::mpse_qstat_t qstat
);
    import mpse_pkg::*;

    mpse_entry_t slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign head        = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/core/mpse_back.sv */
// Byte sequencer: walks the head entry one byte a cycle, while the output is taken, into the output register
`timescale 1ns / 1ps

module mpse_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mpse_pkg::mpse_entry_t head,
    input  mpse_pkg::mpse_qstat_t qstat,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_byte_valid,
    output logic                  m_last,
    output logic                  m_success
);
    import mpse_pkg::*;

    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             bv_reg, bv_next;
    logic             last_reg, last_next;
    logic             succ_reg, succ_next;
    logic             load;
    logic             fin;

    assign load = !qstat.empty && (!valid_reg || m_ready);
    assign fin  = (idx_reg == head.len - 4'd1);
    assign pop  = load && fin;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_ready;
        byte_next  = byte_reg;
        bv_next    = bv_reg;
        last_next  = last_reg;
        succ_next  = succ_reg;
        if (load) begin
            valid_next = 1'b1;
            byte_next  = head.bytes[8*MAX_BYTES-1 - 8*idx_reg -: 8];
            bv_next    = head.byte_valid;
            last_next  = fin;
            succ_next  = fin && head.success;
            idx_next   = fin ? '0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        bv_reg   <= bv_next;
        last_reg <= last_next;
        succ_reg <= succ_next;
    end

    assign m_valid      = valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_byte_valid = bv_reg;
    assign m_last       = last_reg;
    assign m_success    = succ_reg;

endmodule

/* rtl/core/messagepack_scalar_encoder_top.sv */
// MessagePack scalar encoder: turns one request a transaction into encoded bytes
// Input channel s_*: one request per transaction, s_req_type selects the kind
// and s_value carries the operand, size or raw byte.
// Output channel m_*: one transaction per encoded byte, big-endian, m_last on
// the final byte of a request and m_success on it when the element is whole.
// A rejected request, or one with no room for its tag, gives a single
// transaction with m_byte_valid low.
// cfg_wr_en/cfg_wr_data write the capacity register (reset 256); the user
// must write it only while idle, as the block does not enforce this.
// A request of n bytes (1 to 9) waits in the queue, then the byte sequencer
// puts one byte per cycle, while m_ready is high, into the output register.
// A two-entry queue holds encoded requests, so the input keeps accepting
// while the receiver stalls, until the queue fills.
// Reset clears the byte count, the queue and the output valid flag, and
// restores the capacity to 256.
`timescale 1ns / 1ps

module messagepack_scalar_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_req_type,
    input  logic [63:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_last,
    output logic        m_success
);
    import mpse_pkg::*;

    mpse_entry_t push_entry;
    mpse_entry_t head;
    mpse_qstat_t qstat;
    logic        push;
    logic        pop;

    mpse_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_value     (s_value),
        .qstat       (qstat),
        .push        (push),
        .push_entry  (push_entry)
    );

    mpse_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    mpse_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_last       (m_last),
        .m_success    (m_success)
    );

endmodule

/* rtl/core/mpse_checker.sv */
// Port checker for the MessagePack encoder, bound to the top level
`timescale 1ns / 1ps
`include "messagepack_scalar_encoder_top_defines.svh"

module mpse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_byte_valid,
    input logic        m_last,
    input logic        m_success
);

    logic        m_stall;
    logic        m_empty;
    logic        m_good;
    logic [10:0] m_payload;

    assign m_stall   = m_valid && !m_ready;
    assign m_empty   = m_valid && !m_byte_valid;
    assign m_good    = m_valid && m_success;
    assign m_payload = {m_out_byte, m_byte_valid, m_last, m_success};

    `MPSE_ASSERT_NXT(a_m_hold, aclk, !aresetn, m_stall, m_valid, "m_valid dropped")
    `MPSE_ASSERT_NXT(a_m_stable, aclk, !aresetn, m_stall, $stable(m_payload), "payload moved")
    `MPSE_ASSERT_IMP(a_empty_last, aclk, !aresetn, m_empty, m_last && !m_success, "empty not last")
    `MPSE_ASSERT_IMP(a_succ_last, aclk, !aresetn, m_good, m_last && m_byte_valid, "early success")
    `MPSE_ASSERT_NXT(a_reset_idle, aclk, 1'b0, !aresetn, !m_valid && s_ready, "busy after reset")

endmodule

bind messagepack_scalar_encoder_top mpse_checker u_mpse_checker (.*);

/* tb/messagepack_scalar_encoder_top_tb.sv */
// Self-checking testbench for the MessagePack scalar encoder top level
`timescale 1ns / 1ps

module messagepack_scalar_encoder_top_tb;
    import mpse_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic       last;
        logic       success;
    } encoded_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [4:0]  s_req_type;
    logic [63:0] s_value;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic        m_last;
    logic        m_success;

    encoded_byte_t expected_bytes[$];
    int            bytes_written;
    int            buffer_capacity;
    int            mismatch_count = 0;
    bit            tx_gaps_on = 1'b1;
    bit            rx_gaps_on = 1'b1;
    int            rx_hold_cycles = 0;
    int            rx_gap_left = 0;

    messagepack_scalar_encoder_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_last       (m_last),
        .m_success    (m_success)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [71:0] align_bytes(input logic [7:0] tag, input logic [63:0] payload,
                                                input int plen);
        return {tag, payload << (64 - 8 * plen)};
    endfunction

    function automatic int encode_uint(input logic [31:0] u, output logic [71:0] enc);
        if (u <= 32'h7f) begin
            enc = {u[7:0], 64'd0};
            return 1;
        end
        if (u <= 32'hff) begin
            enc = align_bytes(TAG_U8, 64'(u), 1);
            return 2;
        end
        if (u <= 32'hffff) begin
            enc = align_bytes(TAG_U16, 64'(u), 2);
            return 3;
        end
        enc = align_bytes(TAG_U32, 64'(u), 4);
        return 5;
    endfunction

    function automatic logic [63:0] random_operand();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 40));
            2: v = 64'($urandom_range(0, 300));
            3: v = {$urandom, 32'hffff_ffff - 32'($urandom_range(0, 200))};
            4: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
            default: v = {$urandom, 32'($urandom_range(0, 70000))};
        endcase
        return v;
    endfunction

    task automatic encode_request(input logic [4:0] kind, input logic [63:0] v);
        logic [71:0]   enc;
        logic [31:0]   s;
        int            n;
        int            i;
        encoded_byte_t e;
        enc = '0;
        n = 0;
        s = v[31:0];
        case (kind)
            REQ_NIL:   begin enc = {TAG_NIL, 64'd0}; n = 1; end
            REQ_TRUE:  begin enc = {TAG_BOOL_TRUE, 64'd0}; n = 1; end
            REQ_FALSE: begin enc = {TAG_BOOL_FALSE, 64'd0}; n = 1; end
            REQ_ARRAY: if (v <= 64'h0f) begin enc = {TAG_FIXARR | v[7:0], 64'd0}; n = 1; end
            REQ_MAP:   if (v <= 64'h0f) begin enc = {TAG_MAP_FIX | v[7:0], 64'd0}; n = 1; end
            REQ_UINT:  n = encode_uint(s, enc);
            REQ_U8:    begin enc = align_bytes(TAG_U8, v, 1); n = 2; end
            REQ_U16:   begin enc = align_bytes(TAG_U16, v, 2); n = 3; end
            REQ_U32:   begin enc = align_bytes(TAG_U32, v, 4); n = 5; end
            REQ_U64:   begin enc = align_bytes(TAG_U64, v, 8); n = 9; end
            REQ_SINT: begin
                if (!s[31]) begin
                    n = encode_uint(s, enc);
                end else if (s >= 32'hffff_ffe0) begin
                    enc = {s[7:0], 64'd0};
                    n = 1;
                end else if (s >= 32'hffff_ff80) begin
                    enc = align_bytes(TAG_S8, 64'(s), 1);
                    n = 2;
                end else if (s >= 32'hffff_8000) begin
                    enc = align_bytes(TAG_S16, 64'(s), 2);
                    n = 3;
                end else begin
                    enc = align_bytes(TAG_S32, 64'(s), 4);
                    n = 5;
                end
            end
            REQ_S8:    begin enc = align_bytes(TAG_S8, v, 1); n = 2; end
            REQ_S16:   begin enc = align_bytes(TAG_S16, v, 2); n = 3; end
            REQ_S32:   begin enc = align_bytes(TAG_S32, v, 4); n = 5; end
            REQ_S64:   begin enc = align_bytes(TAG_S64, v, 8); n = 9; end
            REQ_F32:   begin enc = align_bytes(TAG_F32, v, 4); n = 5; end
            REQ_F64:   begin enc = align_bytes(TAG_F64, v, 8); n = 9; end
            REQ_STR: begin
                if (v <= 64'h1f) begin
                    enc = {TAG_STR_FIX | v[7:0], 64'd0};
                    n = 1;
                end else if (v <= 64'hff) begin
                    enc = {TAG_STR_8BIT, v[7:0], 56'd0};
                    n = 2;
                end
            end
            REQ_RAW:    begin enc = {v[7:0], 64'd0}; n = 1; end
            REQ_FIXSTR: if (v <= 64'h1f) begin enc = {TAG_STR_FIX | v[7:0], 64'd0}; n = 1; end
            REQ_STR8:   if (v <= 64'hff) begin enc = {TAG_STR_8BIT, v[7:0], 56'd0}; n = 2; end
            default: n = 0;
        endcase

        if (n == 0 || bytes_written >= buffer_capacity) begin
            e = '{data: 8'd0, data_valid: 1'b0, last: 1'b1, success: 1'b0};
            expected_bytes.push_back(e);
        end else begin
            bytes_written++;
            if (n == 1 || bytes_written + n - 1 > buffer_capacity) begin
                e = '{data: enc[71:64], data_valid: 1'b1, last: 1'b1, success: n == 1};
                expected_bytes.push_back(e);
            end else begin
                for (i = 0; i < n; i++) begin
                    e = '{data: enc[71 - 8 * i -: 8], data_valid: 1'b1,
                          last: i == n - 1, success: i == n - 1};
                    expected_bytes.push_back(e);
                end
                bytes_written += n - 1;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // enter at a falling edge, leave at one with valid possibly still high
    task automatic send_request(input logic [4:0] kind, input logic [63:0] v);
        int gap;
        s_req_type = kind;
        s_value = v;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        encode_request(kind, v);
        @(negedge aclk);
        gap = pick_gap(tx_gaps_on);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        drain_results();
        cfg_wr_en = 1'b1;
        cfg_wr_data = cap;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        buffer_capacity = int'(cap);
    endtask

    always @(negedge aclk) begin
        int gap;
        if (rx_hold_cycles > 0) begin
            m_ready = 1'b0;
            rx_hold_cycles--;
        end else if (rx_gap_left > 0) begin
            m_ready = 1'b0;
            rx_gap_left--;
        end else begin
            gap = pick_gap(rx_gaps_on);
            m_ready = (gap == 0);
            rx_gap_left = (gap > 0) ? gap - 1 : 0;
        end
    end

    always @(posedge aclk) begin
        encoded_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction, byte %02h", m_out_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (m_out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, want %02h", m_out_byte, want.data));
                if (m_byte_valid !== want.data_valid)
                    report_mismatch($sformatf("byte_valid %b, want %b", m_byte_valid,
                                              want.data_valid));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", m_last, want.last));
                if (m_success !== want.success)
                    report_mismatch($sformatf("success %b, want %b", m_success, want.success));
            end
        end
    end

    task automatic test_every_kind();
        send_request(REQ_NIL, 64'd0);
        send_request(REQ_TRUE, {$urandom, $urandom});
        send_request(REQ_FALSE, 64'd0);
        send_request(REQ_ARRAY, 64'd15);
        send_request(REQ_MAP, 64'd0);
        send_request(REQ_UINT, 64'h0000_0000_0000_007f);
        send_request(REQ_UINT, 64'hffff_ffff_0001_0000);
        send_request(REQ_UINT, 64'h0000_0000_ffff_ffff);
        send_request(REQ_SINT, 64'h0000_0000_ffff_ffe0);
        send_request(REQ_SINT, 64'h0000_0000_ffff_ffdf);
        send_request(REQ_SINT, 64'h0000_0000_ffff_8000);
        send_request(REQ_SINT, 64'h0000_0000_8000_0000);
        send_request(REQ_U64, 64'hffff_ffff_ffff_ffff);
        send_request(REQ_S16, 64'h1234_5678_9abc_8001);
        send_request(REQ_F32, 64'h0000_0000_3f80_0000);
        send_request(REQ_F64, 64'h4009_21fb_5444_2d18);
        send_request(REQ_STR, 64'd32);
        send_request(REQ_RAW, 64'hffff_ffff_ffff_ffa5);
        send_request(REQ_FIXSTR, 64'd31);
        send_request(REQ_STR8, 64'd255);
    endtask

    task automatic test_rejections();
        send_request(REQ_ARRAY, 64'd16);
        send_request(REQ_MAP, 64'h8000_0000_0000_0000);
        send_request(REQ_FIXSTR, 64'd32);
        send_request(REQ_STR, 64'd256);
        send_request(5'd21, 64'd0);
        send_request(5'd31, 64'hffff_ffff_ffff_ffff);
    endtask

    task automatic test_capacity_limits();
        write_capacity(16'(bytes_written + 3));
        send_request(REQ_U32, 64'h0000_0000_dead_beef);
        send_request(REQ_U8, 64'h0000_0000_0000_00ff);
        send_request(REQ_NIL, 64'd0);
        write_capacity(16'd0);
        send_request(REQ_TRUE, 64'd0);
        write_capacity(16'hffff);
    endtask

    task automatic test_random_stream();
        int          sent;
        int          len;
        int          r;
        bit          squeezed;
        logic [4:0]  hdr;
        sent = 0;
        squeezed = 1'b0;
        while (sent < 60) begin
            if (!squeezed && sent >= 30) begin
                write_capacity(16'(bytes_written + $urandom_range(16, 48)));
                squeezed = 1'b1;
            end
            tx_gaps_on = !(sent >= 15 && sent < 25);
            rx_gaps_on = !(sent >= 15 && sent < 25);
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_request(5'($urandom_range(21, 31)), random_operand());
                sent++;
            end else if (r < 35) begin
                case ($urandom_range(0, 2))
                    0: hdr = REQ_STR;
                    1: hdr = REQ_FIXSTR;
                    default: hdr = REQ_STR8;
                endcase
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
                send_request(hdr, 64'(len));
                repeat (len) send_request(REQ_RAW, {$urandom, $urandom});
                sent += len + 1;
            end else begin
                send_request(5'($urandom_range(0, 20)), random_operand());
                sent++;
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        write_capacity(16'hffff);
        tx_gaps_on = 1'b0;
        rx_hold_cycles = 80;
        repeat (14) send_request($urandom_range(0, 1) ? REQ_F64 : REQ_U64, {$urandom, $urandom});
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_pause_until_empty();
        repeat (4) send_request(5'($urandom_range(0, 20)), random_operand());
        drain_results();
        repeat (4) send_request(5'($urandom_range(0, 20)), random_operand());
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'd0;
        s_valid = 1'b0;
        s_req_type = REQ_NIL;
        s_value = 64'd0;
        bytes_written = 0;
        buffer_capacity = int'(CAPACITY_RESET);
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_every_kind();
        test_rejections();
        test_capacity_limits();
        test_random_stream();
        test_backpressure();
        test_pause_until_empty();

        drain_results();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("messagepack_scalar_encoder_top_tb: clean");
        end else begin
            $display("messagepack_scalar_encoder_top_tb: errors");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("messagepack_scalar_encoder_top_tb: errors");
        $finish;
    end

endmodule

/* messagepack_scalar_encoder_top.f */
+incdir+rtl/core
rtl/core/mpse_pkg.sv
rtl/core/mpse_front.sv
rtl/core/mpse_queue.sv
rtl/core/mpse_back.sv
rtl/core/messagepack_scalar_encoder_top.sv
rtl/core/mpse_checker.sv
tb/messagepack_scalar_encoder_top_tb.sv
